// ===== src/tbn_pkg.sv =====
// ----------------------------------------------------------------------------
// Tree barrier node package
// Shared constants, field codes and the job record that passes from the
// front end through the job queue to the back end.
// ----------------------------------------------------------------------------
`default_nettype none

package tbn_pkg;

    // Widths of the fields
    localparam int RANK_W  = 10;
    localparam int COUNT_W = 11;
    localparam int CFG_W   = 11;

    // Largest group size that the node honours; larger counts are clamped
    localparam int MAX_NODES = 1024;

    // Default number of jobs held between front and back end (power of two)
    localparam int DEF_QUEUE_DEPTH = 4;

    // Input command codes
    localparam logic CMD_ARRIVE  = 1'b0;
    localparam logic CMD_MESSAGE = 1'b1;

    // Message tags
    localparam logic TAG_ARRIVAL = 1'b0;
    localparam logic TAG_WAKEUP  = 1'b1;

    // Result kinds
    localparam logic KIND_SEND    = 1'b0;
    localparam logic KIND_RELEASE = 1'b1;

    // Configuration register indexes
    localparam logic REG_MY_RANK    = 1'b0;
    localparam logic REG_NODE_COUNT = 1'b1;

    // One unit of work for the back end. A wake job sends to the wakeup
    // children that exist and then releases; otherwise one arrival is sent.
    typedef struct packed {
        logic              is_wake;
        logic [RANK_W-1:0] arr_dest;
        logic              c0_ok;
        logic              c1_ok;
        logic [RANK_W-1:0] c0_dest;
        logic [RANK_W-1:0] c1_dest;
    } t_job;

endpackage

`default_nettype wire

// ===== src/tbn_front.sv =====
// ----------------------------------------------------------------------------
// Tree barrier node front end
// Accepts events, keeps the barrier state and turns each event that
// completes an episode or a wakeup into a job for the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module tbn_front import tbn_pkg::*; (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_ready,
    input  wire logic               i_cmd,
    input  wire logic [RANK_W-1:0]  i_src_rank,
    input  wire logic               i_msg_tag,
    input  wire logic [RANK_W-1:0]  i_my_rank,
    input  wire logic [COUNT_W-1:0] i_node_count,
    input  wire logic               i_full,
    output logic                    o_push,
    output t_job                    o_job
);

    logic [3:0] r_mask, n_mask;
    logic       r_local, n_local;
    logic       r_awaiting, n_awaiting;

    logic [COUNT_W-1:0] eff_count;
    logic [12:0]        rank4;
    logic [12:0]        arr_base;
    logic [12:0]        src_off;
    logic [11:0]        wchild0;
    logic [11:0]        wchild1;
    logic [3:0]         need;
    logic               arr_hit;
    logic               is_root;
    logic               msg_wake;
    logic               fire;
    logic               accept;
    logic [RANK_W-1:0]  rank_m1;

    assign eff_count = (i_node_count > COUNT_W'(MAX_NODES)) ? COUNT_W'(MAX_NODES)
                                                             : i_node_count;
    assign rank4    = {1'b0, i_my_rank, 2'b00};
    assign arr_base = rank4 + 13'd1;
    assign src_off  = 13'(i_src_rank) - arr_base;
    assign arr_hit  = (13'(i_src_rank) >= arr_base) && (src_off < 13'd4);
    assign wchild0  = {1'b0, i_my_rank, 1'b1};
    assign wchild1  = {1'b0, i_my_rank, 1'b0} + 12'd2;
    assign is_root  = (i_my_rank == '0);
    assign rank_m1  = i_my_rank - RANK_W'(1);

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            need[i] = ((rank4 + 13'(i + 1)) < 13'(eff_count));
        end
    end

    assign o_ready = ~i_full;
    assign accept  = i_valid & ~i_full;

    always_comb begin
        n_mask     = r_mask;
        n_local    = r_local;
        n_awaiting = r_awaiting;
        msg_wake   = 1'b0;
        priority if (i_cmd == CMD_ARRIVE) begin
            if (!r_local && !r_awaiting) begin
                n_local = 1'b1;
            end
        end else if (i_msg_tag == TAG_ARRIVAL) begin
            if (arr_hit && need[src_off[1:0]]) begin
                n_mask[src_off[1:0]] = 1'b1;
            end
        end else begin
            if (r_awaiting && !is_root && (i_src_rank == {1'b0, rank_m1[RANK_W-1:1]})) begin
                msg_wake   = 1'b1;
                n_awaiting = 1'b0;
            end
        end

        fire = !msg_wake && !n_awaiting && n_local && ((n_mask & need) == need);
        if (fire) begin
            n_mask  = '0;
            n_local = 1'b0;
            if (!is_root) begin
                n_awaiting = 1'b1;
            end
        end
    end

    assign o_push         = accept && (msg_wake || fire);
    assign o_job.is_wake  = msg_wake || is_root;
    assign o_job.arr_dest = {2'b00, rank_m1[RANK_W-1:2]};
    assign o_job.c0_ok    = (wchild0 < 12'(eff_count));
    assign o_job.c1_ok    = (wchild1 < 12'(eff_count));
    assign o_job.c0_dest  = wchild0[RANK_W-1:0];
    assign o_job.c1_dest  = wchild1[RANK_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask     <= '0;
            r_local    <= 1'b0;
            r_awaiting <= 1'b0;
        end else if (accept) begin
            r_mask     <= n_mask;
            r_local    <= n_local;
            r_awaiting <= n_awaiting;
        end
    end

`ifndef NO_ASSERTIONS
    // While waiting for a wakeup the local process has already been counted.
    a_await_no_local: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_awaiting |-> !r_local)
        else $error("front: local arrival pending while awaiting wakeup");
    // A job leaves only with an accepted event.
    a_push_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push |-> (i_valid && !i_full))
        else $error("front: job pushed without an accepted event");
`endif

endmodule

`default_nettype wire

// ===== src/tbn_queue.sv =====
// ----------------------------------------------------------------------------
// Tree barrier node job queue
// Small first-in first-out store of jobs between front and back end.
// ----------------------------------------------------------------------------
`default_nettype none

module tbn_queue import tbn_pkg::*; #(
    parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_job i_job,
    output logic      o_full,
    input  wire logic i_pop,
    output logic      o_valid,
    output t_job      o_job
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_job             r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wptr;
    logic [PTR_W-1:0] r_rptr;
    logic [CNT_W-1:0] r_count;

    assign o_full  = (r_count == CNT_W'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_job   = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= r_wptr + PTR_W'(1);
            end
            if (i_pop) begin
                r_rptr <= r_rptr + PTR_W'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

`ifndef NO_ASSERTIONS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("queue: push while full");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_valid)
        else $error("queue: pop while empty");
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(QUEUE_DEPTH))
        else $error("queue: fill count out of range");
`endif

endmodule

`default_nettype wire

// ===== src/tbn_back.sv =====
// ----------------------------------------------------------------------------
// Tree barrier node back end
// Expands each job into its result transfers, one per cycle unless the
// receiver stalls, into an output register that the receiver drains.
// ----------------------------------------------------------------------------
`default_nettype none

module tbn_back import tbn_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_q_valid,
    input  wire t_job              i_q_job,
    output logic                   o_pop,
    output logic                   o_valid,
    input  wire logic              i_ready,
    output logic                   o_kind,
    output logic [RANK_W-1:0]      o_dest,
    output logic                   o_tag,
    output logic                   o_last
);

    typedef enum logic [3:0] {
        S_C0  = 4'b0001,
        S_C1  = 4'b0010,
        S_REL = 4'b0100,
        S_ARR = 4'b1000
    } t_step;

    logic              r_busy;
    t_job              r_job;
    t_step             r_step;
    logic              r_valid;
    logic              r_kind;
    logic [RANK_W-1:0] r_dest;
    logic              r_tag;
    logic              r_last;

    t_job              cur_job;
    t_step             cur_step;
    t_step             nxt_step;
    logic              cur_valid;
    logic              advance;
    logic              res_kind;
    logic [RANK_W-1:0] res_dest;
    logic              res_tag;
    logic              res_last;

    assign cur_valid = r_busy | i_q_valid;
    assign cur_job   = r_busy ? r_job : i_q_job;

    always_comb begin
        if (r_busy) begin
            cur_step = r_step;
        end else if (!i_q_job.is_wake) begin
            cur_step = S_ARR;
        end else if (i_q_job.c0_ok) begin
            cur_step = S_C0;
        end else if (i_q_job.c1_ok) begin
            cur_step = S_C1;
        end else begin
            cur_step = S_REL;
        end
    end

    always_comb begin
        nxt_step = S_REL;
        res_kind = KIND_SEND;
        res_dest = '0;
        res_tag  = TAG_WAKEUP;
        res_last = 1'b0;
        unique case (cur_step)
            S_C0: begin
                res_dest = cur_job.c0_dest;
                nxt_step = cur_job.c1_ok ? S_C1 : S_REL;
            end
            S_C1: begin
                res_dest = cur_job.c1_dest;
            end
            S_REL: begin
                res_kind = KIND_RELEASE;
                res_tag  = TAG_ARRIVAL;
                res_last = 1'b1;
            end
            S_ARR: begin
                res_dest = cur_job.arr_dest;
                res_tag  = TAG_ARRIVAL;
                res_last = 1'b1;
            end
            default: begin
                res_last = 1'b1;
            end
        endcase
    end

    assign advance = cur_valid && (!r_valid || i_ready);
    assign o_pop   = advance && !r_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            if (advance) begin
                r_valid <= 1'b1;
                r_busy  <= !res_last;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_job  <= cur_job;
            r_step <= nxt_step;
            r_kind <= res_kind;
            r_dest <= res_dest;
            r_tag  <= res_tag;
            r_last <= res_last;
        end
    end

    assign o_valid = r_valid;
    assign o_kind  = r_kind;
    assign o_dest  = r_dest;
    assign o_tag   = r_tag;
    assign o_last  = r_last;

`ifndef NO_ASSERTIONS
    // A job still in progress has only its second child or release to go.
    a_busy_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_step == S_C1 || r_step == S_REL))
        else $error("back: bad step for a job in progress");
    // A job in progress always has a result waiting in the output register.
    a_busy_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> r_valid)
        else $error("back: job in progress without a result shown");
`endif

endmodule

`default_nettype wire

// ===== src/tree_barrier_node_top.sv =====
// ----------------------------------------------------------------------------
// Tree barrier node
// One node of a barrier over a group of ranks: four-way arrival tree,
// two-way wakeup tree.
//
// The input stream carries events: tuser 0 is the local process arriving,
// tuser 1 a received message whose sender and tag sit in tdata. The output
// stream carries message sends (tuser 0) and local releases (tuser 1); tlast
// marks the final transfer caused by one input event. Events that complete
// nothing produce no transfer at all.
// The front end accepts one event per cycle whenever the job queue has room
// and decides at once what the event causes. A job is written into the
// queue and then, when the back end takes it, into the output register; an
// arrival job gives one transfer, a wake job up to three, issued one per
// cycle by the back end while the receiver takes them. The sustained rate
// is set by the back end's single output register: one transfer per cycle.
// When the receiver stalls, the output register holds its transfer, the
// back end pauses and up to QUEUE_DEPTH jobs collect in the queue before
// tready falls. Reset (synchronous, active low) clears the barrier state,
// empties the queue and the output register, and sets rank 0 and a group of
// one. Configuration writes are taken at any edge with the write enable high.
// ----------------------------------------------------------------------------
`default_nettype none

module tree_barrier_node_top import tbn_pkg::*; #(
    parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    // Configuration writes
    input  wire logic              i_cfg_we,
    input  wire logic              i_cfg_addr,
    input  wire logic [CFG_W-1:0]  i_cfg_wdata,
    // Event stream in
    input  wire logic              i_s_tvalid,
    output logic                   o_s_tready,
    input  wire logic [15:0]       i_s_tdata,   // [9:0] src_rank, [10] msg_tag
    input  wire logic              i_s_tuser,   // [0] cmd
    // Result stream out
    output logic                   o_m_tvalid,
    input  wire logic              i_m_tready,
    output logic [15:0]            o_m_tdata,   // [9:0] dest_rank, [10] out_tag
    output logic                   o_m_tuser,   // [0] out_kind
    output logic                   o_m_tlast    // last transfer of one event
);

    logic [RANK_W-1:0]  r_my_rank;
    logic [COUNT_W-1:0] r_node_count;

    logic              q_push;
    logic              q_full;
    logic              q_pop;
    logic              q_valid;
    t_job              push_job;
    t_job              head_job;
    logic [RANK_W-1:0] out_dest;
    logic              out_tag;

    // Configuration registers; user writes only while node is idle, unchecked.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_my_rank    <= '0;
            r_node_count <= COUNT_W'(1);
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                REG_MY_RANK:    r_my_rank    <= i_cfg_wdata[RANK_W-1:0];
                REG_NODE_COUNT: r_node_count <= i_cfg_wdata[COUNT_W-1:0];
                default:        r_my_rank    <= r_my_rank;
            endcase
        end
    end

    tbn_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_s_tvalid),
        .o_ready      (o_s_tready),
        .i_cmd        (i_s_tuser),
        .i_src_rank   (i_s_tdata[RANK_W-1:0]),
        .i_msg_tag    (i_s_tdata[RANK_W]),
        .i_my_rank    (r_my_rank),
        .i_node_count (r_node_count),
        .i_full       (q_full),
        .o_push       (q_push),
        .o_job        (push_job)
    );

    tbn_queue #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_job   (push_job),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_job   (head_job)
    );

    tbn_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_job   (head_job),
        .o_pop     (q_pop),
        .o_valid   (o_m_tvalid),
        .i_ready   (i_m_tready),
        .o_kind    (o_m_tuser),
        .o_dest    (out_dest),
        .o_tag     (out_tag),
        .o_last    (o_m_tlast)
    );

    assign o_m_tdata = {5'b00000, out_tag, out_dest};

endmodule

`default_nettype wire

// ===== sim/tb.sv =====
// ----------------------------------------------------------------------------
// Tree barrier node testbench
// Drives event transfers into the node and checks every result transfer
// against a cycle-free model of the barrier state held in the bench. A
// directed opening covers the root, the extremes of rank and group size, the
// ignored and early events, and a node outside its group. Random phases then
// run whole barrier episodes with noise and broken sequences, under several
// rank and group settings, with random idling on both streams.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;

    import tbn_pkg::*;

    // One event offered on the input stream
    typedef struct packed {
        logic              cmd;
        logic [RANK_W-1:0] src;
        logic              tag;
    } t_barrier_event;

    // One result transfer as the node should produce it
    typedef struct packed {
        logic              kind;
        logic [RANK_W-1:0] dest;
        logic              tag;
        logic              last;
    } t_barrier_result;

    // Generous bound on the whole run, far beyond the slowest correct run.
    localparam int CYCLE_LIMIT  = 300000;
    // Cycles allowed for events still inside the node once nothing is owed.
    localparam int DRAIN_CYCLES = 12;
    // Length of the one long receiver hold-off.
    localparam int HOLD_CYCLES  = 250;
    localparam int RANDOM_ITEMS = 300;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    logic              cfg_we = 1'b0;
    logic              cfg_addr = REG_MY_RANK;
    logic [CFG_W-1:0]  cfg_wdata = '0;

    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [15:0]       s_tdata = '0;
    logic              s_tuser = CMD_ARRIVE;

    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [15:0]       m_tdata;
    logic              m_tuser;
    logic              m_tlast;

    tree_barrier_node_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_addr  (cfg_addr),
        .i_cfg_wdata (cfg_wdata),
        .i_s_tvalid  (s_tvalid),
        .o_s_tready  (s_tready),
        .i_s_tdata   (s_tdata),
        .i_s_tuser   (s_tuser),
        .o_m_tvalid  (m_tvalid),
        .i_m_tready  (m_tready),
        .o_m_tdata   (m_tdata),
        .o_m_tuser   (m_tuser),
        .o_m_tlast   (m_tlast)
    );

    always begin
        i_clk = 1'b0;
        #2;
        i_clk = 1'b1;
        #2;
    end

    // ------------------------------------------------------------------------
    // Barrier state as the bench believes it to be
    // ------------------------------------------------------------------------
    int          node_rank  = 0;
    int          group_size = 1;
    logic [3:0]  child_mask = 4'b0000;
    logic        local_in   = 1'b0;
    logic        wait_wake  = 1'b0;

    t_barrier_event  pending_events[$];
    t_barrier_result owed_results[$];
    t_barrier_result burst_q[$];

    int   events_taken  = 0;
    int   results_seen  = 0;
    int   mismatches    = 0;
    int   settings_used = 0;
    int   random_items  = 0;
    int   cycle_count   = 0;
    logic calm          = 1'b0;
    logic hold_req      = 1'b0;

    function automatic int live_count();
        return (group_size > MAX_NODES) ? MAX_NODES : group_size;
    endfunction

    // Arrival children of this rank that exist in the group.
    function automatic logic [3:0] children_due();
        logic [3:0] m;
        int         n;
        m = 4'b0000;
        n = live_count();
        for (int i = 0; i < 4; i++) begin
            if (4 * node_rank + i + 1 < n)
                m[i] = 1'b1;
        end
        return m;
    endfunction

    function automatic t_barrier_result make_result(logic kind, int dest, logic tag);
        t_barrier_result r;
        r.kind = kind;
        r.dest = dest[RANK_W-1:0];
        r.tag  = tag;
        r.last = 1'b0;
        return r;
    endfunction

    function automatic t_barrier_event make_event(logic cmd, int src, logic tag);
        t_barrier_event e;
        e.cmd = cmd;
        e.src = src[RANK_W-1:0];
        e.tag = tag;
        return e;
    endfunction

    // Waking: wakeups to the existing binary children, lower rank first,
    // then the release of the local process.
    task automatic wake_node();
        int c;
        for (int i = 0; i < 2; i++) begin
            c = 2 * node_rank + i + 1;
            if (c < live_count())
                burst_q.push_back(make_result(KIND_SEND, c, TAG_WAKEUP));
        end
        // A release carries zero in both rank and tag.
        burst_q.push_back(make_result(KIND_RELEASE, 0, 1'b0));
        wait_wake = 1'b0;
    endtask

    // Works out what one accepted event causes and queues those results.
    task automatic predict_event(input logic cmd, input logic [RANK_W-1:0] src_bits,
                                 input logic tag);
        logic [3:0]      need;
        int              src;
        int              base;
        t_barrier_result tail;
        need = children_due();
        src  = src_bits;
        burst_q.delete();
        if (cmd == CMD_ARRIVE) begin
            if (!local_in && !wait_wake)
                local_in = 1'b1;
        end else if (tag == TAG_ARRIVAL) begin
            base = 4 * node_rank + 1;
            if (src >= base && src < base + 4) begin
                if (need[src - base])
                    child_mask[src - base] = 1'b1;
            end
        end else begin
            if (wait_wake && node_rank != 0 && src == (node_rank - 1) / 2)
                wake_node();
        end
        if (burst_q.size() == 0 && !wait_wake && local_in && (child_mask & need) == need) begin
            child_mask = 4'b0000;
            local_in   = 1'b0;
            if (node_rank == 0) begin
                wake_node();
            end else begin
                burst_q.push_back(make_result(KIND_SEND, (node_rank - 1) / 4, TAG_ARRIVAL));
                wait_wake = 1'b1;
            end
        end
        if (burst_q.size() > 0) begin
            tail = burst_q[burst_q.size() - 1];
            tail.last = 1'b1;
            burst_q[burst_q.size() - 1] = tail;
        end
        foreach (burst_q[i])
            owed_results.push_back(burst_q[i]);
    endtask

    // ------------------------------------------------------------------------
    // Input driver: offers pending events, with random bursts of idling.
    // The prediction is made at the edge where a transfer completes.
    // ------------------------------------------------------------------------
    int             send_gap = 0;
    t_barrier_event next_ev;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                predict_event(s_tuser, s_tdata[RANK_W-1:0], s_tdata[RANK_W]);
                events_taken++;
            end
            if (!s_tvalid || s_tready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    s_tvalid <= 1'b0;
                end else if (pending_events.size() == 0) begin
                    s_tvalid <= 1'b0;
                end else if (!calm && $urandom_range(0, 9) == 0) begin
                    // This cycle is the first of an idle burst.
                    send_gap = $urandom_range(0, 7);
                    s_tvalid <= 1'b0;
                end else begin
                    next_ev = pending_events.pop_front();
                    s_tvalid <= 1'b1;
                    s_tuser  <= next_ev.cmd;
                    s_tdata  <= {5'b00000, next_ev.tag, next_ev.src};
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Receiver ready: random stalls, plus one long hold-off on request so that
    // the node's job queue fills and it refuses input.
    // ------------------------------------------------------------------------
    int   stall_left = 0;
    int   hold_left  = 0;
    logic hold_done  = 1'b0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_tready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else if (hold_req && !hold_done) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES - 1;
            m_tready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            m_tready <= 1'b0;
        end else if (!calm && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(0, 7);
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: each result transfer against the oldest owed result.
    // ------------------------------------------------------------------------
    t_barrier_result want;

    always @(posedge i_clk) begin
        if (i_rst_n && m_tvalid && m_tready) begin
            results_seen++;
            if (owed_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: kind %0b dest %0d tag %0b last %0b",
                             m_tuser, m_tdata[RANK_W-1:0], m_tdata[RANK_W], m_tlast);
            end else begin
                want = owed_results.pop_front();
                if (m_tuser !== want.kind || m_tdata[RANK_W-1:0] !== want.dest ||
                    m_tdata[RANK_W] !== want.tag || m_tlast !== want.last) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("result %0d: expected kind %0b dest %0d tag %0b last %0b, got kind %0b dest %0d tag %0b last %0b",
                                 results_seen, want.kind, want.dest, want.tag, want.last,
                                 m_tuser, m_tdata[RANK_W-1:0], m_tdata[RANK_W], m_tlast);
                end
            end
        end
    end

    // Watchdog on the whole run.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results still owed",
                     cycle_count, owed_results.size());
            $display("FAILED: results differ");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------

    // Waits until every event has been taken and every owed result has come,
    // then lets the node finish events that cause nothing.
    task automatic settle();
        while (pending_events.size() != 0 || s_tvalid || owed_results.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Both registers are written while the node is idle; the bench's copy
    // follows at once since nothing is in flight.
    task automatic write_config(input int rank, input int count);
        @(posedge i_clk);
        cfg_we    <= 1'b1;
        cfg_addr  <= REG_MY_RANK;
        cfg_wdata <= rank[CFG_W-1:0];
        @(posedge i_clk);
        cfg_addr  <= REG_NODE_COUNT;
        cfg_wdata <= count[CFG_W-1:0];
        @(posedge i_clk);
        cfg_we    <= 1'b0;
        node_rank  = rank & 10'h3FF;
        group_size = count & 11'h7FF;
        settings_used++;
    endtask

    task automatic push_event(input logic cmd, input int src, input logic tag);
        pending_events.push_back(make_event(cmd, src, tag));
    endtask

    // One barrier episode for the current setting: the child arrivals and the
    // local arrival in random order, then, below the root, the parent's wakeup.
    // Some episodes lose an event, get a wrong wakeup sender, or carry noise.
    task automatic queue_episode();
        t_barrier_event seq[$];
        t_barrier_event tmp;
        int             n;
        int             pick;
        int             src;
        n = live_count();
        for (int i = 0; i < 4; i++) begin
            if (4 * node_rank + i + 1 < n)
                seq.push_back(make_event(CMD_MESSAGE, 4 * node_rank + i + 1, TAG_ARRIVAL));
        end
        // The sender and tag of a local arrival are ignored, so they carry noise.
        seq.push_back(make_event(CMD_ARRIVE, $urandom_range(0, 1023), $urandom_range(0, 1)));
        for (int j = seq.size() - 1; j > 0; j--) begin
            pick      = $urandom_range(0, j);
            tmp       = seq[j];
            seq[j]    = seq[pick];
            seq[pick] = tmp;
        end
        if ($urandom_range(0, 9) == 0)
            seq.delete($urandom_range(0, seq.size() - 1));
        if (node_rank != 0) begin
            src = (node_rank - 1) / 2;
            if ($urandom_range(0, 9) == 0)
                src = $urandom_range(0, 1023);
            seq.push_back(make_event(CMD_MESSAGE, src, TAG_WAKEUP));
        end
        random_items += seq.size();
        foreach (seq[i]) begin
            pending_events.push_back(seq[i]);
            if ($urandom_range(0, 5) == 0) begin
                push_event($urandom_range(0, 1), $urandom_range(0, 1023), $urandom_range(0, 1));
                random_items++;
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------
    int r;
    int c;

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Root of a group of one, straight from reset: each local arrival
        // releases at once; messages at the root from nowhere do nothing.
        push_event(CMD_ARRIVE, 0, TAG_ARRIVAL);
        push_event(CMD_MESSAGE, 0, TAG_ARRIVAL);
        push_event(CMD_MESSAGE, 0, TAG_WAKEUP);
        push_event(CMD_ARRIVE, 1023, TAG_WAKEUP);
        settle();

        // Rank 1 of the largest group: four arrival children, two wakeup
        // children. A repeated local arrival while waiting is ignored; early
        // arrivals for the next episode are kept, a repeat leaves the bit set;
        // wakeups from the wrong rank and arrivals from strangers do nothing.
        write_config(1, 1024);
        push_event(CMD_MESSAGE, 5, TAG_ARRIVAL);
        push_event(CMD_MESSAGE, 6, TAG_ARRIVAL);
        push_event(CMD_MESSAGE, 7, TAG_ARRIVAL);
        push_event(CMD_ARRIVE, 0, TAG_ARRIVAL);
        push_event(CMD_MESSAGE, 8, TAG_ARRIVAL);
        push_event(CMD_ARRIVE, 0, TAG_ARRIVAL);
        push_event(CMD_MESSAGE, 5, TAG_ARRIVAL);
        push_event(CMD_MESSAGE, 5, TAG_ARRIVAL);
        push_event(CMD_MESSAGE, 1, TAG_WAKEUP);
        push_event(CMD_MESSAGE, 9, TAG_ARRIVAL);
        push_event(CMD_MESSAGE, 1023, TAG_ARRIVAL);
        push_event(CMD_MESSAGE, 0, TAG_WAKEUP);
        push_event(CMD_MESSAGE, 1023, TAG_WAKEUP);
        settle();

        // Highest rank with a count beyond the largest group, which is
        // clamped: no children, so arrival and wakeup alone.
        write_config(1023, 2047);
        push_event(CMD_MESSAGE, 511, TAG_WAKEUP);
        push_event(CMD_ARRIVE, 0, TAG_ARRIVAL);
        push_event(CMD_MESSAGE, 511, TAG_WAKEUP);
        settle();

        // A node outside an empty group still takes part through its parent.
        write_config(5, 0);
        push_event(CMD_ARRIVE, 0, TAG_ARRIVAL);
        push_event(CMD_MESSAGE, 2, TAG_WAKEUP);
        settle();

        // Long receiver hold-off at a root that wakes two children: results
        // pile up in the node until it stops taking events.
        write_config(0, 3);
        hold_req = 1'b1;
        repeat (2) @(posedge i_clk);
        for (int k = 0; k < 8; k++)
            queue_episode();
        settle();

        // Random phases, each under its own setting. The node is left alone
        // between phases until all owed results have come.
        while (random_items < RANDOM_ITEMS) begin
            case ($urandom_range(0, 5))
                0: begin
                    r = 0;
                    c = $urandom_range(1, 9);
                end
                1: begin
                    r = $urandom_range(1, 20);
                    c = 4 * r + 1 + $urandom_range(0, 4);
                end
                2: begin
                    r = $urandom_range(0, 1023);
                    c = $urandom_range(0, 2047);
                end
                3: begin
                    r = 255;
                    c = 1024;
                end
                4: begin
                    r = $urandom_range(1, 255);
                    c = $urandom_range(0, 1) ? 1024 : 2047;
                end
                default: begin
                    r = $urandom_range(1, 300);
                    c = $urandom_range(0, r);
                end
            endcase
            write_config(r, c);
            for (int k = $urandom_range(2, 5); k > 0; k--)
                queue_episode();
            // The closing stretch runs without idling on either side.
            if (random_items >= RANDOM_ITEMS - 50)
                calm = 1'b1;
            settle();
        end

        settle();
        if (owed_results.size() != 0) begin
            mismatches++;
            $display("%0d results never arrived", owed_results.size());
        end

        $display("covered %0d events and %0d results over %0d rank and group settings",
                 events_taken, results_seen, settings_used);
        $display("with one long output hold-off and random idling on both streams");
        if (mismatches == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("%0d mismatches in total", mismatches);
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule

`default_nettype wire
